FILE: src/bbr_pkg.sv
// shared types and constants of the 3x3 rgb box blur
package bbr_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int DIM_W       = 12;
  localparam int ROW_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int SUM_W       = 12;
  localparam int DIV9_W      = 13;
  localparam int DIV9_SHIFT  = 16;
  localparam int WIN_SIZE    = 9;

  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0]  MIN_DIM      = DIM_W'(3);
  localparam logic [DIM_W-1:0]  WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_LIMIT    = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX      = SUM_W'(9 * 255);
  // ceil(2^16 / 9): exact floor(x / 9) for every 9-pixel sum
  localparam logic [DIV9_W-1:0] DIV9_MULT    = DIV9_W'(7282);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } pixel_sum_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_flags_t;

endpackage

FILE: src/bbr_in_if.sv
// pixel input channel: valid/ready plus mode and rgb channels
interface bbr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, mode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

FILE: src/bbr_out_if.sv
// pixel output channel: valid/ready plus rgb channels and frame end
interface bbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

FILE: src/box_blur_3x3_rgb_core.sv
// streaming 3x3 box blur on rgb pixels with two line stores
//
//   channel  dir  handshake             payload
//   pix_i    in   pix_i.valid/ready     mode, in_red, in_green, in_blue
//   pix_o    out  pix_o.valid/ready     out_red, out_green, out_blue, frame_end
//   cfg      in   cfg_we_i              cfg_index_i, cfg_data_i
//
// one item per clock unless the output stalls; a result reaches the output
// register after the transfer of the item that completes it, which is W+1
// items after its pixel. the stages are counters/ram read, window shift/ram
// write, channel sums, and the divide by 9 into the output register.
// pix_i.ready is low only while the output register holds an untaken result; then
// every stage holds. reset clears counters, window and valid bits, config to 640x480.
module box_blur_3x3_rgb_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbr_pkg::DIM_W-1:0]          cfg_data_i,
  bbr_in_if.sink                             pix_i,
  bbr_out_if.source                          pix_o
);

  // configuration, stored already clamped
  logic [bbr_pkg::DIM_W-1:0] width_q, height_q;

  // frame counters
  logic [bbr_pkg::COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [bbr_pkg::ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  // handshake and accept-stage decode
  logic                  advance;
  logic                  in_fire;
  logic                  take;
  logic                  ignore;
  logic                  col_wrap;
  logic                  out_col_wrap;
  logic                  out_row_end;
  logic [bbr_pkg::ROW_W:0] out_row_inc;
  bbr_pkg::item_flags_t  flags_s0;
  bbr_pkg::pixel_t       pix_s0;

  // stage 1: ram read in flight
  logic                      v1_q;
  bbr_pkg::item_flags_t      flags1_q;
  bbr_pkg::pixel_t           pix1_q;
  logic [bbr_pkg::COL_W-1:0] col1_q;

  // stage 2: window holds the item's neighbourhood
  logic                 v2_q;
  bbr_pkg::item_flags_t flags2_q;
  bbr_pkg::pixel_t      window_q [bbr_pkg::WIN_SIZE];

  // stage 3: channel sums
  logic                 v3_q;
  bbr_pkg::item_flags_t flags3_q;
  bbr_pkg::pixel_sum_t  sum3_q;
  bbr_pkg::pixel_t      centre3_q;
  bbr_pkg::pixel_sum_t  win_sum;

  // output register
  logic                 out_valid_q;
  logic                 out_last_q;
  bbr_pkg::pixel_t      out_pix_q;
  bbr_pkg::pixel_t      result;

  // line stores
  bbr_pkg::pixel_t      upper_rdata, lower_rdata;
  logic                 store_we;

  function automatic logic [bbr_pkg::CHAN_W-1:0] div9(input logic [bbr_pkg::SUM_W-1:0] s);
    logic [bbr_pkg::SUM_W+bbr_pkg::DIV9_W-1:0] prod;
    prod = {{bbr_pkg::DIV9_W{1'b0}}, s} * {{bbr_pkg::SUM_W{1'b0}}, bbr_pkg::DIV9_MULT};
    return prod[bbr_pkg::DIV9_SHIFT +: bbr_pkg::CHAN_W];
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbr_pkg::WIDTH_RESET;
      height_q <= bbr_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (bbr_pkg::cfg_reg_e'(cfg_index_i))
        bbr_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data_i < bbr_pkg::MIN_DIM) begin
            width_q <= bbr_pkg::MIN_DIM;
          end else if (cfg_data_i > bbr_pkg::WIDTH_MAX) begin
            width_q <= bbr_pkg::WIDTH_MAX;
          end else begin
            width_q <= cfg_data_i;
          end
        end
        bbr_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= (cfg_data_i < bbr_pkg::MIN_DIM) ? bbr_pkg::MIN_DIM : cfg_data_i;
        end
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- accept stage
  assign advance     = !out_valid_q || pix_o.ready;
  assign pix_i.ready = advance;
  assign in_fire     = pix_i.valid && advance;

  always_comb begin
    // a drain at the very start of a frame does nothing
    ignore       = pix_i.mode && (in_row_q == '0) && (in_col_q == '0);
    take         = in_fire && !ignore;
    pix_s0       = pix_i.mode ? '0 : {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
    col_wrap     = ({1'b0, in_col_q} + bbr_pkg::DIM_W'(1)) >= width_q;
    out_col_wrap = ({1'b0, out_col_q} + bbr_pkg::DIM_W'(1)) >= width_q;
    out_row_inc  = {1'b0, out_row_q} + (bbr_pkg::ROW_W + 1)'(1);
    out_row_end  = out_row_inc >= {1'b0, height_q};

    flags_s0.emit     = (in_row_q >= bbr_pkg::ROW_W'(2)) ||
                        ((in_row_q == bbr_pkg::ROW_W'(1)) && (in_col_q != '0));
    flags_s0.interior = (out_row_q != '0) && !out_row_end &&
                        (out_col_q != '0) && !out_col_wrap;
    flags_s0.last     = out_row_end && out_col_wrap;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      if (col_wrap) begin
        in_col_d = '0;
        if (in_row_q < bbr_pkg::ROW_LIMIT) begin
          in_row_d = in_row_q + bbr_pkg::ROW_W'(1);
        end
      end else begin
        in_col_d = in_col_q + bbr_pkg::COL_W'(1);
      end
      if (flags_s0.emit) begin
        if (flags_s0.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_wrap) begin
          out_col_d = '0;
          if (out_row_q < bbr_pkg::ROW_LIMIT) begin
            out_row_d = out_row_q + bbr_pkg::ROW_W'(1);
          end
        end else begin
          out_col_d = out_col_q + bbr_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------------------------------------------------------- line stores
  assign store_we = advance && v1_q;

  bbr_ram #(
    .WIDTH (bbr_pkg::PIX_W),
    .DEPTH (bbr_pkg::MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (col1_q),
    .wdata_i (lower_rdata),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (upper_rdata)
  );

  bbr_ram #(
    .WIDTH (bbr_pkg::PIX_W),
    .DEPTH (bbr_pkg::MAX_WIDTH)
  ) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (col1_q),
    .wdata_i (pix1_q),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (lower_rdata)
  );

  // ---------------------------------------------------------------- pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= take;
      v2_q        <= v1_q && flags1_q.emit;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // window shifts left, newest column enters on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bbr_pkg::WIN_SIZE; i++) begin
        window_q[i] <= '0;
      end
    end else if (store_we) begin
      for (int r = 0; r < 3; r++) begin
        window_q[r*3]   <= window_q[r*3+1];
        window_q[r*3+1] <= window_q[r*3+2];
      end
      window_q[2] <= upper_rdata;
      window_q[5] <= lower_rdata;
      window_q[8] <= pix1_q;
    end
  end

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < bbr_pkg::WIN_SIZE; i++) begin
      win_sum.red   = win_sum.red   + bbr_pkg::SUM_W'(window_q[i].red);
      win_sum.green = win_sum.green + bbr_pkg::SUM_W'(window_q[i].green);
      win_sum.blue  = win_sum.blue  + bbr_pkg::SUM_W'(window_q[i].blue);
    end
  end

  always_comb begin
    if (flags3_q.interior) begin
      result.red   = div9(sum3_q.red);
      result.green = div9(sum3_q.green);
      result.blue  = div9(sum3_q.blue);
    end else begin
      result = centre3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (take) begin
        flags1_q <= flags_s0;
        pix1_q   <= pix_s0;
        col1_q   <= in_col_q;
      end
      if (v1_q) begin
        flags2_q <= flags1_q;
      end
      if (v2_q) begin
        flags3_q  <= flags2_q;
        sum3_q    <= win_sum;
        centre3_q <= window_q[4];
      end
      if (v3_q) begin
        out_pix_q  <= result;
        out_last_q <= flags3_q.last;
      end
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_red   = out_pix_q.red;
  assign pix_o.out_green = out_pix_q.green;
  assign pix_o.out_blue  = out_pix_q.blue;
  assign pix_o.frame_end = out_last_q;

`ifndef SYNTHESIS
  a_ready_when_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> pix_i.ready)
    else $error("input stalled with free output register");

  a_frame_end_clears_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && flags_s0.emit && flags_s0.last |=>
      in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
    else $error("counters not cleared after last pixel of frame");

  a_width_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= bbr_pkg::MIN_DIM && width_q <= bbr_pkg::WIDTH_MAX &&
    height_q >= bbr_pkg::MIN_DIM)
    else $error("frame size register out of range");

  a_sum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> sum3_q.red <= bbr_pkg::SUM_MAX && sum3_q.green <= bbr_pkg::SUM_MAX &&
             sum3_q.blue <= bbr_pkg::SUM_MAX)
    else $error("window sum exceeds nine full-scale pixels");

  a_output_from_pipeline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v3_q))
    else $error("output valid without an item in the sum stage");
`endif

endmodule

FILE: src/bbr_ram.sv
// generic simple dual-port ram, registered write-first read
module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a read of the address written in the same cycle returns the new data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
